FILE: rtl/core/tiny_vm_instruction_step_macros.svh
// Assertion macros shared by the RTL of the instruction step block.
// Both forms expect a clock named clk in scope; ASSERT_AT also expects an active-high reset named rst.
`ifndef TINY_VM_INSTRUCTION_STEP_MACROS_SVH
`define TINY_VM_INSTRUCTION_STEP_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_AT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_AT(label, prop, msg)
`define ASSERT_NR(label, prop, msg)
`endif

`endif

FILE: rtl/core/tvm_pkg.sv
package tvm_pkg;

  localparam int VAL_BITS   = 64;
  localparam int A_BITS     = 16;
  localparam int SLOT_BITS  = 16;
  localparam int NPC_BITS   = 16;
  localparam int DIGIT_BITS = 8;

  localparam logic [1:0] REQ_EXEC  = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [3:0] OP_SET    = 4'd0;
  localparam logic [3:0] OP_CMP    = 4'd1;
  localparam logic [3:0] OP_ADD    = 4'd2;
  localparam logic [3:0] OP_IN2ST  = 4'd3;
  localparam logic [3:0] OP_ST2OUT = 4'd4;
  localparam logic [3:0] OP_RES2ST = 4'd5;
  localparam logic [3:0] OP_JMP    = 4'd6;
  localparam logic [3:0] OP_JE     = 4'd7;
  localparam logic [3:0] OP_JNE    = 4'd8;
  localparam logic [3:0] OP_JL     = 4'd9;
  localparam logic [3:0] OP_JLE    = 4'd10;
  localparam logic [3:0] OP_JG     = 4'd11;
  localparam logic [3:0] OP_JGE    = 4'd12;

  localparam logic [1:0] FLAG_EQ   = 2'd0;
  localparam logic [1:0] FLAG_LT   = 2'd1;
  localparam logic [1:0] FLAG_GT   = 2'd2;
  localparam logic [1:0] FLAG_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]                 req_type;
    logic [3:0]                 opcode;
    logic signed [A_BITS-1:0]   operand_a;
    logic signed [VAL_BITS-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [NPC_BITS-1:0]        next_pc;
    logic                       out_valid;
    logic [SLOT_BITS-1:0]       out_slot;
    logic signed [VAL_BITS-1:0] out_value;
    logic [1:0]                 flag_now;
  } rsp_t;

endpackage

FILE: rtl/core/tvm_ram.sv
module tvm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int READS = 1,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr [READS],
  output logic [WIDTH-1:0] rdata [READS]
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < READS; i++) begin
      rdata[i] <= mem[raddr[i]];
    end
  end

endmodule

FILE: rtl/core/tvm_mod_reduce.sv
module tvm_mod_reduce #(
  parameter int DIVISOR = 64,
  localparam int IdxW = (DIVISOR > 1) ? $clog2(DIVISOR) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tvm_pkg::VAL_BITS-1:0] value,
  output logic                         busy,
  output logic [IdxW-1:0]              index
);

  import tvm_pkg::*;

  localparam bit POW2 = (DIVISOR & (DIVISOR - 1)) == 0;

  // Weight of digit k: 2^(k*DIGIT_BITS) reduced below the divisor.
  function automatic longint unsigned weight(input int k);
    longint unsigned w;
    w = 64'd1;
    for (int i = 0; i < k * DIGIT_BITS; i++) begin
      w = w * 64'd2;
      if (w >= 64'(DIVISOR)) begin
        w = w - 64'(DIVISOR);
      end
    end
    return w;
  endfunction

  if (POW2) begin : g_mask
    localparam logic [VAL_BITS-1:0] MASK = VAL_BITS'(DIVISOR - 1);
    logic [VAL_BITS-1:0] masked;

    assign masked = value & MASK;
    assign busy   = 1'b0;

    always_ff @(posedge clk) begin
      if (rst) begin
        index <= '0;
      end else if (start) begin
        index <= masked[IdxW-1:0];
      end
    end
  end else begin : g_fold
    localparam int STEPS = VAL_BITS / DIGIT_BITS;
    localparam int SUMW  = DIGIT_BITS + IdxW + $clog2(STEPS);
    localparam int SH    = SUMW + IdxW;
    localparam int RCW   = SUMW + 1;
    localparam int PW    = SUMW + RCW;
    localparam int QW    = PW - SH;
    localparam logic [PW-1:0] RECIP =
      PW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
    localparam logic [SUMW-1:0] DIV = SUMW'(DIVISOR);

    logic [SUMW-1:0] term [STEPS];
    logic [SUMW-1:0] fold;
    logic [SUMW-1:0] folded;
    logic [PW-1:0]   prod;
    logic [QW-1:0]   quot;
    logic [SUMW-1:0] diff;
    logic [IdxW-1:0] rem;
    logic [1:0]      left;

    // Each digit times its weight keeps the value modulo the divisor, so the
    // 64-bit operand folds into a short sum. The sum is then divided exactly
    // by a multiply with a rounded-up reciprocal, and the remainder follows.
    for (genvar k = 0; k < STEPS; k++) begin : g_term
      localparam logic [SUMW-1:0] W = SUMW'(weight(k));
      assign term[k] = SUMW'(value[k*DIGIT_BITS +: DIGIT_BITS]) * W;
    end

    always_comb begin
      fold = '0;
      for (int k = 0; k < STEPS; k++) begin
        fold = fold + term[k];
      end
    end

    assign prod = PW'(folded) * RECIP;
    assign diff = folded - SUMW'(quot) * DIV;

    always_ff @(posedge clk) begin
      if (rst) begin
        left <= '0;
        rem  <= '0;
      end else if (start) begin
        folded <= fold;
        left   <= 2'd2;
      end else if (left == 2'd2) begin
        quot <= prod[SH +: QW];
        left <= 2'd1;
      end else if (left == 2'd1) begin
        rem  <= diff[IdxW-1:0];
        left <= 2'd0;
      end
    end

    assign busy  = (left != '0);
    assign index = rem;
  end

endmodule

FILE: rtl/core/tiny_vm_instruction_step.sv
// Instruction step engine for a small 64-bit virtual machine.
// Request channel (req_valid/req_stall/req_data): one word per item, either an
// instruction to execute, a load of an input slot, or a clear but for the flag.
// Response channel (rsp_valid/rsp_stall/rsp_data): exactly one word per item,
// carrying the next program counter, the output write if any and the flag.
// Timing: an accepted item first forms its memory indexes and issues the store
// and input bank reads, then executes on the registered read data and writes
// back; no new item is taken until it has executed. With power-of-two memory
// depths each index is a registered mask of the operand; otherwise the index
// reduction folds the operand and divides by a reciprocal multiply, registering
// the fold, the quotient and the remainder in turn while the item waits.
// The response appears the cycle after execution and waits in an output
// register, so a new request is taken while it is still stalled; execution of
// the following item holds only when that register is still occupied.
// Reset, and every clear request, starts a sweep that zeroes the store and the
// input bank, one entry per cycle up to the larger of the two depths; req_stall
// stays high meanwhile. The compare flag resets to "none", and a clear request
// leaves it as it is.
`include "tiny_vm_instruction_step_macros.svh"

module tiny_vm_instruction_step #(
  parameter int STORE_WORDS = 64,
  parameter int INPUT_WORDS = 16,
  parameter int PC_BITS     = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  tvm_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output tvm_pkg::rsp_t rsp_data
);

  import tvm_pkg::*;

  localparam int SAW   = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int IAW   = (INPUT_WORDS > 1) ? $clog2(INPUT_WORDS) : 1;
  localparam int SWEEP = (STORE_WORDS > INPUT_WORDS) ? STORE_WORDS : INPUT_WORDS;
  localparam int CW    = $clog2(SWEEP + 1);
  localparam logic [CW-1:0] SWEEP_LAST = CW'(SWEEP - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_INDEX = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_CLEAR = 4'b1000
  } state_t;

  state_t              state;
  req_t                item;
  logic [CW-1:0]       sweep;
  logic [PC_BITS-1:0]  pc;
  logic [PC_BITS-1:0]  pc_next;
  logic [1:0]          flag;
  logic [1:0]          flag_next;
  logic [VAL_BITS-1:0] result_word;
  logic [VAL_BITS-1:0] result_word_next;
  rsp_t                rsp_next;

  logic                accept;
  logic                go;
  logic [VAL_BITS-1:0] a_zext;
  logic [31:0]         a_sext;

  logic [SAW-1:0] sa_idx;
  logic [SAW-1:0] sb_idx;
  logic [IAW-1:0] ia_idx;
  logic [IAW-1:0] ib_idx;
  logic [3:0]     red_busy;

  logic                st_we;
  logic [SAW-1:0]      st_waddr;
  logic [VAL_BITS-1:0] st_wdata;
  logic [SAW-1:0]      st_raddr [2];
  logic [VAL_BITS-1:0] st_rd [2];
  logic                st_wr;
  logic [VAL_BITS-1:0] st_val;

  logic                in_we;
  logic [IAW-1:0]      in_waddr;
  logic [VAL_BITS-1:0] in_wdata;
  logic [IAW-1:0]      in_raddr [1];
  logic [VAL_BITS-1:0] in_rd [1];
  logic                in_wr;

  logic jump_taken;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);
  assign go        = (state == ST_EXEC) && (!rsp_valid || !rsp_stall);
  assign a_zext    = {{(VAL_BITS - A_BITS){1'b0}}, req_data.operand_a};
  assign a_sext    = {{(32 - A_BITS){item.operand_a[A_BITS-1]}}, item.operand_a};

  // Index reduction for the four places an operand selects a memory entry.
  tvm_mod_reduce #(.DIVISOR(STORE_WORDS)) u_red_sa (
    .clk, .rst, .start(accept), .value(a_zext),
    .busy(red_busy[0]), .index(sa_idx)
  );
  tvm_mod_reduce #(.DIVISOR(STORE_WORDS)) u_red_sb (
    .clk, .rst, .start(accept), .value(req_data.operand_b),
    .busy(red_busy[1]), .index(sb_idx)
  );
  tvm_mod_reduce #(.DIVISOR(INPUT_WORDS)) u_red_ia (
    .clk, .rst, .start(accept), .value(a_zext),
    .busy(red_busy[2]), .index(ia_idx)
  );
  tvm_mod_reduce #(.DIVISOR(INPUT_WORDS)) u_red_ib (
    .clk, .rst, .start(accept), .value(req_data.operand_b),
    .busy(red_busy[3]), .index(ib_idx)
  );

  // Reads run every cycle; the indexes hold from the index cycle through
  // execution, and an item writes back only after its own reads are used, so
  // the next item always reads what the last one wrote.
  assign st_raddr[0] = sa_idx;
  assign st_raddr[1] = sb_idx;
  assign in_raddr[0] = ib_idx;

  tvm_ram #(.WIDTH(VAL_BITS), .DEPTH(STORE_WORDS), .READS(2)) u_store (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rd)
  );

  tvm_ram #(.WIDTH(VAL_BITS), .DEPTH(INPUT_WORDS), .READS(1)) u_input (
    .clk, .we(in_we), .waddr(in_waddr), .wdata(in_wdata),
    .raddr(in_raddr), .rdata(in_rd)
  );

  always_comb begin
    case (item.opcode)
      OP_JMP:  jump_taken = 1'b1;
      OP_JE:   jump_taken = (flag == FLAG_EQ);
      OP_JNE:  jump_taken = (flag != FLAG_EQ);
      OP_JL:   jump_taken = (flag == FLAG_LT);
      OP_JLE:  jump_taken = (flag == FLAG_LT) || (flag == FLAG_EQ);
      OP_JG:   jump_taken = (flag == FLAG_GT);
      OP_JGE:  jump_taken = (flag == FLAG_GT) || (flag == FLAG_EQ);
      default: jump_taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_next          = pc;
    flag_next        = flag;
    result_word_next = result_word;
    st_wr            = 1'b0;
    st_val           = item.operand_b;
    in_wr            = 1'b0;
    rsp_next         = '0;

    case (item.req_type)
      REQ_EXEC: begin
        pc_next = pc + PC_BITS'(1);
        case (item.opcode)
          OP_SET: begin
            st_wr = 1'b1;
          end
          OP_CMP: begin
            if (st_rd[0] == st_rd[1]) begin
              flag_next = FLAG_EQ;
            end else if ($signed(st_rd[0]) < $signed(st_rd[1])) begin
              flag_next = FLAG_LT;
            end else begin
              flag_next = FLAG_GT;
            end
          end
          OP_ADD: begin
            result_word_next = st_rd[0] + st_rd[1];
          end
          OP_IN2ST: begin
            st_wr  = 1'b1;
            st_val = in_rd[0];
          end
          OP_ST2OUT: begin
            rsp_next.out_valid = 1'b1;
            rsp_next.out_slot  = item.operand_a;
            rsp_next.out_value = st_rd[1];
          end
          OP_RES2ST: begin
            st_wr  = 1'b1;
            st_val = (item.operand_b == '0) ? result_word : '0;
          end
          default: begin
            if (jump_taken) begin
              pc_next = pc + PC_BITS'(1) + a_sext[PC_BITS-1:0];
            end
          end
        endcase
      end
      REQ_LOAD: begin
        in_wr = 1'b1;
      end
      REQ_CLEAR: begin
        pc_next          = '0;
        result_word_next = '0;
      end
      default: begin
      end
    endcase

    rsp_next.next_pc  = NPC_BITS'(pc_next);
    rsp_next.flag_now = flag_next;
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      st_we    = (32'(sweep) < STORE_WORDS);
      st_waddr = SAW'(sweep);
      st_wdata = '0;
      in_we    = (32'(sweep) < INPUT_WORDS);
      in_waddr = IAW'(sweep);
      in_wdata = '0;
    end else begin
      st_we    = go && st_wr;
      st_waddr = sa_idx;
      st_wdata = st_val;
      in_we    = go && in_wr;
      in_waddr = ia_idx;
      in_wdata = item.operand_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      sweep       <= '0;
      pc          <= '0;
      flag        <= FLAG_NONE;
      result_word <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            state <= ST_INDEX;
          end
        end
        ST_INDEX: begin
          if (red_busy == '0) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (go) begin
            sweep <= '0;
            state <= (item.req_type == REQ_CLEAR) ? ST_CLEAR : ST_IDLE;
          end
        end
        ST_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == SWEEP_LAST) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (go) begin
        pc          <= pc_next;
        flag        <= flag_next;
        result_word <= result_word_next;
        rsp_valid   <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req_data;
    end
    if (go) begin
      rsp_data <= rsp_next;
    end
  end

  `ASSERT_NR(a_reset_sweeps, rst |=> (state == ST_CLEAR) && !rsp_valid, "reset did not start clear")
  `ASSERT_AT(a_accept_index, accept |=> (state == ST_INDEX), "accepted word skipped indexing")
  `ASSERT_AT(a_rsp_from_exec, $rose(rsp_valid) |-> ($past(state) == ST_EXEC), "response without execution")
  `ASSERT_AT(a_clear_zeroed, (state == ST_CLEAR) |-> (pc == '0) && (result_word == '0), "clear with live state")

endmodule
